// File: rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg: shared types, constants and ROM builders for the peak compressor
// Widths of the fixed-point datapath, configuration layout, controller
// commands and the log2 / exp2 lookup tables built at elaboration.
// ----------------------------------------------------------------------------
package pdc_pkg;

	// sample and table sizing
	localparam int SAMPLE_BITS = 24;
	localparam int TAB_BITS    = 8;
	localparam int TAB_SIZE    = 1 << TAB_BITS;

	// datapath widths
	localparam int ENV_W  = 25;                 // envelope, unsigned Q1.24
	localparam int LZD_W  = 5;                  // leading-one position of the envelope
	localparam int OCT_W  = 5;                  // whole octaves below full scale
	localparam int NEG_W  = OCT_W + 16;         // negative log2 of envelope, Q.16
	localparam int DBM_W  = 16;                 // dB magnitude, Q8.8
	localparam int OVR_W  = 18;                 // signed excess over threshold
	localparam int OVP_W  = 15;                 // positive excess
	localparam int PS_W   = 31;                 // excess times slope
	localparam int LOG_W  = 22;                 // attenuation in log2, Q.16
	localparam int GAIN_W = 17;                 // gain, Q0.16 with unity
	localparam int TOT_W  = 21;                 // gain times makeup, Q4.16
	localparam int MA_W   = (SAMPLE_BITS > PS_W) ? SAMPLE_BITS : PS_W;
	localparam int MB_W   = 24;
	localparam int MP_W   = MA_W + MB_W;

	localparam int DB_K = 394566;               // 20*log10(2) in Q8.8 scaled by 2^24 / 2^16
	localparam int LG_K = 10885;                // log2(10)/20 scaled for the slope product

	localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << 16);

	// configuration layout
	localparam int THR_W      = 15;
	localparam int SLOPE_W    = 16;
	localparam int COEF_W     = 24;
	localparam int MAKEUP_W   = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 3'd6;

	typedef struct packed {
		logic signed [THR_W-1:0] threshold_db;
		logic [SLOPE_W-1:0]      ratio_slope;
		logic [COEF_W-1:0]       attack_coef;
		logic [COEF_W-1:0]       release_coef;
		logic [MAKEUP_W-1:0]     makeup_gain;
		logic                    stereo_enable;
		logic                    bypass;
	} cfg_t;

	// multiplier operand selection
	typedef enum logic [2:0] {
		MS_NONE   = 3'd0,
		MS_ENV    = 3'd1,
		MS_DB     = 3'd2,
		MS_SLOPE  = 3'd3,
		MS_K      = 3'd4,
		MS_MAKEUP = 3'd5,
		MS_LEFT   = 3'd6,
		MS_RIGHT  = 3'd7
	} mul_sel_t;

	typedef struct packed {
		logic     ld_in;
		logic     ld_dir;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_env;
		logic     ld_lzd;
		logic     ld_neg;
		logic     ld_over;
		logic     ld_gain;
		logic     ld_total;
		logic     ld_left;
		logic     ld_right;
		logic     ld_out;
	} dp_cmd_t;

	typedef logic [15:0] log_rom_t [TAB_SIZE];
	typedef logic [GAIN_W-1:0] exp_rom_t [TAB_SIZE];

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// log2(1 + k/2^TAB_BITS) in Q0.16, by repeated squaring
	function automatic log_rom_t build_log_rom();
		log_rom_t    rom;
		logic [63:0] x;
		logic [15:0] r;
		for (int k = 0; k < TAB_SIZE; k++) begin
			x = (64'd1 << 30) + (64'(k) << (30 - TAB_BITS));
			r = '0;
			for (int i = 1; i <= 16; i++) begin
				x = (x * x) >> 30;
				if (x >= (64'd1 << 31)) begin
					x = x >> 1;
					r[16-i] = 1'b1;
				end
			end
			rom[k] = r;
		end
		return rom;
	endfunction

	// 2^(-k/2^TAB_BITS) in Q0.16, rounded
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] roots [TAB_BITS+1];
		logic [63:0] x;
		roots[0] = 64'd1 << 29;
		for (int j = 1; j <= TAB_BITS; j++) roots[j] = isqrt64(roots[j-1] << 30);
		for (int k = 0; k < TAB_SIZE; k++) begin
			x = 64'd1 << 30;
			for (int b = 0; b < TAB_BITS; b++) begin
				if (((k >> b) & 1) != 0) x = (x * roots[TAB_BITS-b] + (64'd1 << 29)) >> 30;
			end
			rom[k] = GAIN_W'((x + (64'd1 << 13)) >> 14);
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();
	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// File: rtl/pdc_regs.sv
// ----------------------------------------------------------------------------
// pdc_regs: configuration register file
// Decodes writes on the configuration channel into the seven control
// registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module pdc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pdc_pkg::cfg_t                    cfg
);
	import pdc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_db  <= -15'sd3072;
			cfg_q.ratio_slope   <= 16'd49152;
			cfg_q.attack_coef   <= 24'd34914;
			cfg_q.release_coef  <= 24'd3495;
			cfg_q.makeup_gain   <= 20'd65536;
			cfg_q.stereo_enable <= 1'b1;
			cfg_q.bypass        <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold_db  <= $signed(cfg_data[THR_W-1:0]);
				REG_SLOPE:     cfg_q.ratio_slope   <= cfg_data[SLOPE_W-1:0];
				REG_ATTACK:    cfg_q.attack_coef   <= cfg_data[COEF_W-1:0];
				REG_RELEASE:   cfg_q.release_coef  <= cfg_data[COEF_W-1:0];
				REG_MAKEUP:    cfg_q.makeup_gain   <= cfg_data[MAKEUP_W-1:0];
				REG_STEREO:    cfg_q.stereo_enable <= cfg_data[0];
				REG_BYPASS:    cfg_q.bypass        <= cfg_data[0];
				default: begin
					// unused index: drop
				end
			endcase
		end
	end

endmodule

// File: rtl/pdc_ctrl.sv
// ----------------------------------------------------------------------------
// pdc_ctrl: frame sequencer
// Steps one frame through the envelope, log, gain and output scaling
// phases of the shared datapath, all skipped in bypass, and owns the result valid flag.
// ----------------------------------------------------------------------------
module pdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	output logic             frame_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  logic             bypass,
	output pdc_pkg::dp_cmd_t cmd
);
	import pdc_pkg::*;

	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_MENV  = 16'h0002,
		ST_ENV   = 16'h0004,
		ST_LZD   = 16'h0008,
		ST_NEG   = 16'h0010,
		ST_MDB   = 16'h0020,
		ST_OVER  = 16'h0040,
		ST_MSLP  = 16'h0080,
		ST_MK    = 16'h0100,
		ST_GAIN  = 16'h0200,
		ST_MMK   = 16'h0400,
		ST_TOTAL = 16'h0800,
		ST_ML    = 16'h1000,
		ST_SATL  = 16'h2000,
		ST_SATR  = 16'h4000,
		ST_DONE  = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   accept;
	logic   out_free;

	assign frame_stall  = (state_q != ST_IDLE);
	assign accept       = frame_valid && !frame_stall;
	assign result_valid = res_valid_q;
	assign out_free     = !res_valid_q || !result_stall;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MS_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.ld_in = 1'b1;
					state_d   = bypass ? ST_DONE : ST_MENV;
				end
			end
			ST_MENV: begin
				cmd.ld_dir  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_ENV;
				state_d     = ST_ENV;
			end
			ST_ENV: begin
				cmd.ld_env = 1'b1;
				state_d    = ST_LZD;
			end
			ST_LZD: begin
				cmd.ld_lzd = 1'b1;
				state_d    = ST_NEG;
			end
			ST_NEG: begin
				cmd.ld_neg = 1'b1;
				state_d    = ST_MDB;
			end
			ST_MDB: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_DB;
				state_d     = ST_OVER;
			end
			ST_OVER: begin
				cmd.ld_over = 1'b1;
				state_d     = ST_MSLP;
			end
			ST_MSLP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SLOPE;
				state_d     = ST_MK;
			end
			ST_MK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_K;
				state_d     = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.ld_gain = 1'b1;
				state_d     = ST_MMK;
			end
			ST_MMK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_MAKEUP;
				state_d     = ST_TOTAL;
			end
			ST_TOTAL: begin
				cmd.ld_total = 1'b1;
				state_d      = ST_ML;
			end
			ST_ML: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_LEFT;
				state_d     = ST_SATL;
			end
			ST_SATL: begin
				// retire left while the right product is formed
				cmd.ld_left = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_RIGHT;
				state_d     = ST_SATR;
			end
			ST_SATR: begin
				cmd.ld_right = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall) res_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/pdc_dp.sv
// ----------------------------------------------------------------------------
// pdc_dp: compressor datapath
// Envelope follower, log2 and exp2 lookups, one shared multiplier with a
// product register, output rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module pdc_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pdc_pkg::dp_cmd_t                       cmd,
	input  pdc_pkg::cfg_t                          cfg,
	input  logic signed [pdc_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [pdc_pkg::SAMPLE_BITS-1:0] right_in,
	output logic signed [pdc_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [pdc_pkg::SAMPLE_BITS-1:0] right_out,
	output logic [pdc_pkg::GAIN_W-1:0]             gain_applied
);
	import pdc_pkg::*;

	localparam int V_W = SAMPLE_BITS + 5;

	function automatic logic [SAMPLE_BITS-1:0] mag_of(logic [SAMPLE_BITS-1:0] s);
		return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
	endfunction

	function automatic logic [ENV_W-1:0] to_q24(logic [SAMPLE_BITS-1:0] m);
		logic [SAMPLE_BITS+ENV_W-1:0] w;
		w = {m, {ENV_W{1'b0}}} >> SAMPLE_BITS;
		return w[ENV_W-1:0];
	endfunction

	// round-half-up magnitude, restore sign, clamp to the sample range
	function automatic logic [SAMPLE_BITS-1:0] sat_scale(logic [MP_W:0] rnd, logic neg);
		logic [V_W-1:0]         v;
		logic [V_W-1:0]         lim;
		logic [SAMPLE_BITS-1:0] r;
		v   = rnd[16 +: V_W];
		lim = V_W'(1) << (SAMPLE_BITS - 1);
		if (neg) begin
			if (v >= lim) r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			else          r = SAMPLE_BITS'(~v + 1'b1);
		end else begin
			if (v >= lim) r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			else          r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	logic [SAMPLE_BITS-1:0] l_q, r_q;
	logic                   byp_q;
	logic [ENV_W-1:0]       peak_q;
	logic [ENV_W-1:0]       env_q;
	logic                   dir_q;
	logic [MP_W-1:0]        prod_q;
	logic [LZD_W-1:0]       m_q;
	logic [TAB_BITS-1:0]    idx_q;
	logic                   unity_q;
	logic [NEG_W-1:0]       neg_q;
	logic [OVP_W-1:0]       over_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [TOT_W-1:0]       total_q;
	logic [SAMPLE_BITS-1:0] left_q, right_q;
	logic [SAMPLE_BITS-1:0] left_out_q, right_out_q;
	logic [GAIN_W-1:0]      gain_out_q;

	logic [ENV_W-1:0]          pk_l, pk_r, peak;
	logic                      rising;
	logic [ENV_W-1:0]          diff;
	logic [MA_W-1:0]           op_a;
	logic [MB_W-1:0]           op_b;
	logic [MP_W:0]             rnd15, rnd23;
	logic [ENV_W-1:0]          step;
	logic [LZD_W-1:0]          lead;
	logic [ENV_W+TAB_BITS-1:0] lzd_sh;
	logic [OCT_W-1:0]          oct;
	logic [NEG_W-1:0]          neg;
	logic [DBM_W-1:0]          dbm;
	logic signed [OVR_W-1:0]   dbm_s, thr_s, over_s;
	logic                      over_pos;
	logic [LOG_W-1:0]          atten;
	logic [LOG_W-17:0]         shift_n;
	logic [TAB_BITS-1:0]       gidx;
	logic [GAIN_W-1:0]         gain;

	// peak of the active channels
	always_comb begin
		pk_l = to_q24(mag_of(left_in));
		pk_r = to_q24(mag_of(right_in));
		peak = (cfg.stereo_enable && (pk_r > pk_l)) ? pk_r : pk_l;
	end

	assign rising = peak_q > env_q;
	assign diff   = rising ? (peak_q - env_q) : (env_q - peak_q);

	// shared multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			MS_ENV: begin
				op_a = MA_W'(diff);
				op_b = rising ? cfg.attack_coef : cfg.release_coef;
			end
			MS_DB: begin
				op_a = MA_W'(neg_q);
				op_b = MB_W'(DB_K);
			end
			MS_SLOPE: begin
				op_a = MA_W'(over_q);
				op_b = MB_W'(cfg.ratio_slope);
			end
			MS_K: begin
				op_a = MA_W'(prod_q[PS_W-1:0]);
				op_b = MB_W'(LG_K);
			end
			MS_MAKEUP: begin
				op_a = MA_W'(gain_q);
				op_b = MB_W'(cfg.makeup_gain);
			end
			MS_LEFT: begin
				op_a = MA_W'(mag_of(l_q));
				op_b = MB_W'(total_q);
			end
			MS_RIGHT: begin
				op_a = MA_W'(mag_of(r_q));
				op_b = MB_W'(total_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign rnd15 = {1'b0, prod_q} + (MP_W+1)'(1 << 15);
	assign rnd23 = {1'b0, prod_q} + (MP_W+1)'(1 << 23);
	assign step  = rnd23[24 +: ENV_W];

	// leading one of the envelope and the mantissa bits below it
	always_comb begin
		lead = '0;
		for (int i = 0; i < ENV_W; i++) begin
			if (env_q[i]) lead = LZD_W'(i);
		end
		lzd_sh = {env_q, {TAB_BITS{1'b0}}} >> lead;
	end

	assign oct = OCT_W'(ENV_W - 1) - OCT_W'(m_q);
	assign neg = {oct, 16'b0} - NEG_W'(LOG_ROM[idx_q]);

	always_comb begin
		dbm      = rnd23[24 +: DBM_W];
		dbm_s    = OVR_W'(dbm);
		thr_s    = OVR_W'($signed(cfg.threshold_db));
		over_s   = -dbm_s - thr_s;
		over_pos = !over_s[OVR_W-1] && (over_s != '0);
	end

	always_comb begin
		atten   = rnd23[24 +: LOG_W];
		shift_n = atten[LOG_W-1:16];
		gidx    = atten[15 -: TAB_BITS];
		if (unity_q)                          gain = GAIN_UNITY;
		else if (shift_n >= (LOG_W-16)'(GAIN_W)) gain = '0;
		else                                  gain = EXP_ROM[gidx] >> shift_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (cmd.ld_env) begin
			env_q <= dir_q ? (env_q + step) : (env_q - step);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			l_q    <= left_in;
			r_q    <= right_in;
			byp_q  <= cfg.bypass;
			peak_q <= peak;
		end
		if (cmd.ld_dir) dir_q <= rising;
		if (cmd.mul_en) prod_q <= MP_W'(op_a) * MP_W'(op_b);
		if (cmd.ld_lzd) begin
			m_q     <= lead;
			idx_q   <= lzd_sh[TAB_BITS-1:0];
			unity_q <= (env_q == '0) || (cfg.ratio_slope == '0);
		end
		if (cmd.ld_neg) neg_q <= neg;
		if (cmd.ld_over) begin
			over_q  <= over_s[OVP_W-1:0];
			unity_q <= unity_q || !over_pos;
		end
		if (cmd.ld_gain)  gain_q  <= gain;
		if (cmd.ld_total) total_q <= rnd15[16 +: TOT_W];
		if (cmd.ld_left)  left_q  <= sat_scale(rnd15, l_q[SAMPLE_BITS-1]);
		if (cmd.ld_right) begin
			right_q <= cfg.stereo_enable ? sat_scale(rnd15, r_q[SAMPLE_BITS-1]) : '0;
		end
		if (cmd.ld_out) begin
			left_out_q  <= byp_q ? l_q : left_q;
			right_out_q <= byp_q ? r_q : right_q;
			gain_out_q  <= byp_q ? GAIN_UNITY : gain_q;
		end
	end

	assign left_out     = left_out_q;
	assign right_out    = right_out_q;
	assign gain_applied = gain_out_q;

endmodule

// File: rtl/peak_dynamics_compressor.sv
// ----------------------------------------------------------------------------
// peak_dynamics_compressor: feed-forward peak compressor, hard knee
// Stereo Q1.23 frames in, compressed and saturated frames out, together
// with the reduction gain that was applied.
// ----------------------------------------------------------------------------
// Usage:
//   Frame channel: left_in/right_in transfer when frame_valid is high and
//   frame_stall is low. Result channel: left_out/right_out/gain_applied
//   transfer when result_valid is high and result_stall is low.
//   Configuration channel: cfg_data is written to register cfg_index when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write
//   registers only while no frame is in flight.
//   The sequencer walks each frame through a single shared multiplier
//   (seven products) plus the log, gain and rounding steps in between, and
//   takes no new frame until the last one has gone to the output register.
//   In bypass the frame goes straight to the output register and the
//   envelope is left untouched.
//   A finished result waits in the output register while the next frame is
//   already being accepted and processed; if the receiver still stalls when
//   that frame is done, the sequencer holds and frame_stall stays high.
//   Reset clears the envelope, empties the result register and loads the
//   default register values (-12 dB threshold, 4:1, unity makeup, stereo).
// ----------------------------------------------------------------------------
module peak_dynamics_compressor (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   frame_valid,
	output logic                                   frame_stall,
	input  logic signed [pdc_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [pdc_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [pdc_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [pdc_pkg::SAMPLE_BITS-1:0] right_out,
	output logic [pdc_pkg::GAIN_W-1:0]             gain_applied,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import pdc_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;

	pdc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.bypass       (cfg.bypass),
		.cmd          (cmd)
	);

	pdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.left_in      (left_in),
		.right_in     (right_in),
		.left_out     (left_out),
		.right_out    (right_out),
		.gain_applied (gain_applied)
	);

endmodule
